/* hw/rtl/ffh_pkg.sv */
// ----------------------------------------------------------------------------
// ffh_pkg: shared types and constants of the first-fit heap allocator
// Heap geometry, chunk header layout, command, status and register codes.
// ----------------------------------------------------------------------------
package ffh_pkg;

    localparam int HEAP_BYTES  = 1024;
    localparam int HDR_BYTES   = 4;
    localparam int SLOTS       = HEAP_BYTES / HDR_BYTES;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int LAST_SLOT   = SLOTS - 1;
    localparam int SIZE_W      = $clog2(HEAP_BYTES);
    localparam int MAX_PAYLOAD = HEAP_BYTES - HDR_BYTES;

    localparam int REQ_W    = 16;
    localparam int OFF_W    = 11;
    localparam int GRANT_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 8;
    localparam int REG_IDX_W = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_SPLIT_MARGIN   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_MERGE_INTERVAL = 1'd1;

    localparam logic [CFG_W-1:0] SPLIT_MARGIN_RST   = 8'd16;
    localparam logic [CFG_W-1:0] MERGE_INTERVAL_RST = 8'd10;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef struct packed {
        logic              alloc_mode;
        logic [SLOT_W-1:0] slot;
        hdr_t              entry;
        logic [SIZE_W-1:0] partner_size;
        logic [SIZE_W-1:0] want;
        logic [CFG_W-1:0]  margin;
    } alu_req_t;

    typedef struct packed {
        logic              fits;
        logic              split_ok;
        logic              step_ok;
        logic [SLOT_W-1:0] step_slot;
        logic [SIZE_W-1:0] remainder;
        logic [SIZE_W-1:0] merged;
    } alu_rsp_t;

endpackage

/* hw/rtl/ffh_ram.sv */
// ----------------------------------------------------------------------------
// ffh_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ffh_walk_alu.sv */
// ----------------------------------------------------------------------------
// ffh_walk_alu: shared header arithmetic of the allocator
// Fit test, next-header step, split test and remainder, merged chunk size.
// ----------------------------------------------------------------------------
module ffh_walk_alu import ffh_pkg::*; (
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic              fits;
    logic [SIZE_W-1:0] step_size;
    logic [SLOT_W:0]   step_full;
    logic [SIZE_W:0]   split_need;

    always_comb begin
        fits       = !req.entry.used && (req.entry.size >= req.want);
        step_size  = (req.alloc_mode && fits) ? req.want : req.entry.size;
        step_full  = {1'b0, req.slot} + (SLOT_W+1)'(1)
                   + (SLOT_W+1)'(step_size[SIZE_W-1:2]);
        split_need = {1'b0, req.want} + (SIZE_W+1)'(HDR_BYTES)
                   + (SIZE_W+1)'(req.margin);

        rsp.fits      = fits;
        rsp.step_ok   = step_full < (SLOT_W+1)'(LAST_SLOT);
        rsp.step_slot = step_full[SLOT_W-1:0];
        rsp.split_ok  = fits && ({1'b0, req.entry.size} >= split_need) && rsp.step_ok;
        rsp.remainder = req.entry.size - req.want - SIZE_W'(HDR_BYTES);
        rsp.merged    = req.entry.size + SIZE_W'(HDR_BYTES) + req.partner_size;
    end

endmodule

/* hw/rtl/first_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator with split/coalesce
// Walks implicit 4-byte chunk headers held in a 256-entry ram.
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   tuser: command; tdata: size, offset
//   m_       out  m_tvalid/m_tready   tuser: status; tdata: granted, merged
//   cfg_     in   cfg_wen             cfg_index, cfg_wdata
//
// allocate: decode, then a header read for each chunk walked, and a further write
// of the used header for a split; free: a bad offset is answered at decode,
// else the header is read and, if used, freed; a coalescing pass walks every
// header and merges free neighbours, paced by the single ram read port shared
// by every header access; after reset a clearing pass writes every header, no item
// is taken meanwhile; a stalled result holds the next result back
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit import ffh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // request_size, data_offset, zero fill
    input  logic [0:0]           s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // granted_offset, merged, zero fill
    output logic [STATUS_W-1:0]  m_tuser,   // status
    input  logic                 cfg_wen,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_DECODE  = 10'b0000000100,
        S_A_EVAL  = 10'b0000001000,
        S_A_SPLIT = 10'b0000010000,
        S_F_EVAL  = 10'b0000100000,
        S_M_RD    = 10'b0001000000,
        S_M_A     = 10'b0010000000,
        S_M_B     = 10'b0100000000,
        S_RESP    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                cmd_reg, cmd_next;
    logic [REQ_W-1:0]    size_reg, size_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [SIZE_W-1:0]   want_reg, want_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   nxt_reg, nxt_next;
    hdr_t                cur_reg, cur_next;
    logic [CFG_W-1:0]    fc_reg, fc_next;
    logic [CFG_W-1:0]    margin_reg, margin_next;
    logic [CFG_W-1:0]    interval_reg, interval_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [GRANT_W-1:0]  res_granted_reg, res_granted_next;
    logic                res_merged_reg, res_merged_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [GRANT_W-1:0]  out_granted_reg, out_granted_next;
    logic                out_merged_reg, out_merged_next;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    hdr_t                ram_wdata;
    logic [SLOT_W-1:0]   rd_addr;
    logic [$bits(hdr_t)-1:0] ram_rdata;
    hdr_t                rd_hdr;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    logic [REQ_W:0]      want_wide;
    logic                free_ok;
    logic [CFG_W-1:0]    fc_inc;
    logic [GRANT_W-1:0]  grant_off;

    ffh_ram #(
        .WIDTH ($bits(hdr_t)),
        .DEPTH (SLOTS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    ffh_walk_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign rd_hdr    = hdr_t'(ram_rdata);
    assign want_wide = ({1'b0, size_reg} + (REQ_W+1)'(3)) & ~(REQ_W+1)'(3);
    assign free_ok   = (off_reg >= OFF_W'(HDR_BYTES)) && (off_reg < OFF_W'(HEAP_BYTES))
                     && (off_reg[1:0] == 2'b00);
    assign fc_inc    = fc_reg + CFG_W'(1);
    assign grant_off = {slot_reg + SLOT_W'(1), 2'b00};

    always_comb begin
        alu_req.alloc_mode   = (state_reg == S_A_EVAL);
        alu_req.slot         = slot_reg;
        alu_req.entry        = (state_reg == S_M_B) ? cur_reg : rd_hdr;
        alu_req.partner_size = rd_hdr.size;
        alu_req.want         = want_reg;
        alu_req.margin       = margin_reg;
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cmd_next         = cmd_reg;
        size_next        = size_reg;
        off_next         = off_reg;
        want_next        = want_reg;
        slot_next        = slot_reg;
        nxt_next         = nxt_reg;
        cur_next         = cur_reg;
        fc_next          = fc_reg;
        margin_next      = margin_reg;
        interval_next    = interval_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_merged_next  = res_merged_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_merged_next  = out_merged_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = '0;
        rd_addr          = slot_reg;

        if (cfg_wen) begin
            unique case (cfg_index)
                REG_SPLIT_MARGIN:   margin_next   = cfg_wdata;
                REG_MERGE_INTERVAL: interval_next = cfg_wdata;
                default:            interval_next = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                if (clr_cnt_reg == '0) begin
                    ram_wdata.size = SIZE_W'(MAX_PAYLOAD);
                end
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == SLOT_W'(LAST_SLOT)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[0];
                    size_next  = s_tdata[REQ_W-1:0];
                    off_next   = s_tdata[REQ_W+OFF_W-1:REQ_W];
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_granted_next = '0;
                res_merged_next  = 1'b0;
                if (cmd_reg == CMD_ALLOC) begin
                    if (size_reg == '0 || want_wide > (REQ_W+1)'(MAX_PAYLOAD)) begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = S_RESP;
                    end else begin
                        want_next  = want_wide[SIZE_W-1:0];
                        slot_next  = '0;
                        rd_addr    = '0;
                        state_next = S_A_EVAL;
                    end
                end else begin
                    if (free_ok) begin
                        slot_next  = off_reg[SLOT_W+1:2] - SLOT_W'(1);
                        rd_addr    = off_reg[SLOT_W+1:2] - SLOT_W'(1);
                        state_next = S_F_EVAL;
                    end else begin
                        res_status_next = STATUS_IGNORED;
                        state_next      = S_RESP;
                    end
                end
            end
            S_A_EVAL: begin
                if (alu_rsp.fits) begin
                    ram_we = 1'b1;
                    if (alu_rsp.split_ok) begin
                        ram_waddr      = alu_rsp.step_slot;
                        ram_wdata.used = 1'b0;
                        ram_wdata.size = alu_rsp.remainder;
                        state_next     = S_A_SPLIT;
                    end else begin
                        ram_wdata.used   = 1'b1;
                        ram_wdata.size   = rd_hdr.size;
                        res_status_next  = STATUS_ALLOCATED;
                        res_granted_next = grant_off;
                        state_next       = S_RESP;
                    end
                end else if (alu_rsp.step_ok) begin
                    slot_next = alu_rsp.step_slot;
                    rd_addr   = alu_rsp.step_slot;
                end else begin
                    res_status_next = STATUS_NO_SPACE;
                    state_next      = S_RESP;
                end
            end
            S_A_SPLIT: begin
                ram_we           = 1'b1;
                ram_wdata.used   = 1'b1;
                ram_wdata.size   = want_reg;
                res_status_next  = STATUS_ALLOCATED;
                res_granted_next = grant_off;
                state_next       = S_RESP;
            end
            S_F_EVAL: begin
                if (rd_hdr.used) begin
                    ram_we          = 1'b1;
                    ram_wdata.used  = 1'b0;
                    ram_wdata.size  = rd_hdr.size;
                    res_status_next = STATUS_FREED;
                    if (fc_inc >= interval_reg) begin
                        fc_next         = '0;
                        res_merged_next = 1'b1;
                        slot_next       = '0;
                        state_next      = S_M_RD;
                    end else begin
                        fc_next    = fc_inc;
                        state_next = S_RESP;
                    end
                end else begin
                    res_status_next = STATUS_IGNORED;
                    state_next      = S_RESP;
                end
            end
            S_M_RD: begin
                state_next = S_M_A;
            end
            S_M_A: begin
                cur_next = rd_hdr;
                if (!alu_rsp.step_ok) begin
                    state_next = S_RESP;
                end else if (!rd_hdr.used) begin
                    nxt_next   = alu_rsp.step_slot;
                    rd_addr    = alu_rsp.step_slot;
                    state_next = S_M_B;
                end else begin
                    slot_next = alu_rsp.step_slot;
                    rd_addr   = alu_rsp.step_slot;
                end
            end
            S_M_B: begin
                if (!rd_hdr.used) begin
                    ram_we         = 1'b1;
                    ram_wdata.used = 1'b0;
                    ram_wdata.size = alu_rsp.merged;
                    state_next     = S_M_RD;
                end else begin
                    slot_next  = nxt_reg;
                    rd_addr    = nxt_reg;
                    state_next = S_M_A;
                end
            end
            S_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_granted_next = res_granted_reg;
                    out_merged_next  = res_merged_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            fc_reg        <= '0;
            margin_reg    <= SPLIT_MARGIN_RST;
            interval_reg  <= MERGE_INTERVAL_RST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            fc_reg        <= fc_next;
            margin_reg    <= margin_next;
            interval_reg  <= interval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        size_reg        <= size_next;
        off_reg         <= off_next;
        want_reg        <= want_next;
        slot_reg        <= slot_next;
        nxt_reg         <= nxt_next;
        cur_reg         <= cur_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_merged_reg  <= res_merged_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_merged_reg  <= out_merged_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(16-GRANT_W-1){1'b0}}, out_merged_reg, out_granted_reg};

`ifndef NO_ASSERTIONS
    a_no_item_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("item taken during clearing pass");

    a_grant_only_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STATUS_ALLOCATED) |-> (m_tdata[GRANT_W-1:0] == '0))
        else $error("offset granted without allocation");

    a_grant_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_ALLOCATED)
        |-> (m_tdata[1:0] == 2'b00 && m_tdata[GRANT_W-1:0] != '0))
        else $error("granted offset not a data word");

    a_merge_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[GRANT_W]) |-> (m_tuser == STATUS_FREED))
        else $error("merge flagged on a result that is no free");

    a_merge_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_F_EVAL && state_next == S_M_RD) |=> (fc_reg == '0))
        else $error("free count not cleared by coalescing pass");
`endif

endmodule

/* tb/sv/first_fit_heap_allocator_unit_test.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit_test: self-checking bench for the heap allocator
// Drives allocate and free requests over the stream input with random gaps,
// keeps its own copy of the chunk headers and the free tally, and compares
// every result item field by field in order. Phases run under several split
// margin and merge interval settings, written while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit_test;
    import ffh_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 322;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted;
        logic                merged;
    } outcome_t;

    class heap_shadow;
        logic [16:0]      hdr_word[SLOTS];
        logic [CFG_W-1:0] free_tally;
        logic [CFG_W-1:0] split_margin;
        logic [CFG_W-1:0] merge_interval;
        outcome_t         awaited_outcomes[$];
        int               held_offsets[$];
        int               flaw;

        function new();
            foreach (hdr_word[i]) hdr_word[i] = '0;
            hdr_word[0]    = 17'(MAX_PAYLOAD);
            free_tally     = '0;
            split_margin   = SPLIT_MARGIN_RST;
            merge_interval = MERGE_INTERVAL_RST;
            flaw           = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_SPLIT_MARGIN) begin
                split_margin = val;
            end else if (idx == REG_MERGE_INTERVAL) begin
                merge_interval = val;
            end
        endfunction

        function int size_at(int off);
            return int'(hdr_word[off >> 2][15:0]);
        endfunction

        function bit used_at(int off);
            return hdr_word[off >> 2][16];
        endfunction

        function void coalesce_pass();
            int off;
            int nxt;
            off = 0;
            while (off < MAX_PAYLOAD) begin
                if (!used_at(off)) begin
                    nxt = off + HDR_BYTES + size_at(off);
                    if (nxt < MAX_PAYLOAD && !used_at(nxt)) begin
                        hdr_word[off >> 2] = {1'b0, 16'(size_at(off) + HDR_BYTES + size_at(nxt))};
                        continue;
                    end
                end
                off += HDR_BYTES + size_at(off);
            end
        endfunction

        function bit place_chunk(int req, output int grant);
            int want;
            int off;
            int sz;
            grant = 0;
            if (req == 0) return 1'b0;
            want = (req + 3) & ~3;
            off  = 0;
            while (off < MAX_PAYLOAD) begin
                sz = size_at(off);
                if (!used_at(off) && sz >= want) begin
                    if (sz >= want + HDR_BYTES + int'(split_margin) &&
                        off + HDR_BYTES + want < MAX_PAYLOAD) begin
                        hdr_word[(off + HDR_BYTES + want) >> 2] =
                            {1'b0, 16'(sz - want - HDR_BYTES)};
                        hdr_word[off >> 2] = {1'b1, 16'(want)};
                    end else begin
                        hdr_word[off >> 2][16] = 1'b1;
                    end
                    grant = off + HDR_BYTES;
                    return 1'b1;
                end
                off += HDR_BYTES + sz;
            end
            return 1'b0;
        endfunction

        function void note_request(logic cmd, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
            outcome_t e;
            int       g;
            int       d;
            e = '0;
            if (cmd == CMD_ALLOC) begin
                if (place_chunk(int'(req), g)) begin
                    e.status  = STATUS_ALLOCATED;
                    e.granted = GRANT_W'(g);
                    held_offsets.push_back(g);
                end else begin
                    e.status = STATUS_NO_SPACE;
                end
            end else begin
                d        = int'(off);
                e.status = STATUS_IGNORED;
                if (d >= HDR_BYTES && d < HEAP_BYTES && d % HDR_BYTES == 0 &&
                    used_at(d - HDR_BYTES)) begin
                    hdr_word[(d - HDR_BYTES) >> 2][16] = 1'b0;
                    e.status   = STATUS_FREED;
                    free_tally = free_tally + 1'b1;
                    if (free_tally >= merge_interval) begin
                        coalesce_pass();
                        free_tally = '0;
                        e.merged   = 1'b1;
                    end
                    for (int i = 0; i < held_offsets.size(); i++) begin
                        if (held_offsets[i] == d) begin
                            held_offsets.delete(i);
                            break;
                        end
                    end
                end
            end
            awaited_outcomes.push_back(e);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [GRANT_W-1:0] granted,
                                   logic merged);
            outcome_t e;
            if (awaited_outcomes.size() == 0) begin
                flaw++;
                if (flaw <= SHOW_LIMIT)
                    $display("unexpected result: status %0d granted %0d merged %0d",
                             status, granted, merged);
                return;
            end
            e = awaited_outcomes.pop_front();
            if (status !== e.status || granted !== e.granted || merged !== e.merged) begin
                flaw++;
                if (flaw <= SHOW_LIMIT)
                    $display("mismatch: expected status %0d granted %0d merged %0d, got %0d %0d %0d",
                             e.status, e.granted, e.merged, status, granted, merged);
            end
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;     // request_size, data_offset, zero fill
    logic [0:0]           s_tuser = '0;     // command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;          // granted_offset, merged, zero fill
    logic [STATUS_W-1:0]  m_tuser;          // status
    logic                 cfg_wen = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    heap_shadow heap = new();
    int         gap_pct = 20;
    int         idle_cycles = 0;

    first_fit_heap_allocator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= gap_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            heap.check_result(m_tuser, m_tdata[GRANT_W-1:0], m_tdata[GRANT_W]);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("first_fit_heap_allocator_unit verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [REQ_W-1:0] req,
                             input logic [OFF_W-1:0] off);
        @(negedge aclk);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(32 - REQ_W - OFF_W){1'b0}}, off, req};
        do @(posedge aclk); while (s_tready !== 1'b1);
        heap.note_request(cmd, req, off);
    endtask

    task automatic drain(input int tail);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (heap.pending() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        heap.set_register(idx, val);
    endtask

    task automatic run_directed();
        send_item(CMD_ALLOC, 16'd0, 11'd0);
        send_item(CMD_ALLOC, 16'hFFFF, 11'h7FF);
        send_item(CMD_ALLOC, 16'd65533, 11'd0);
        send_item(CMD_ALLOC, 16'(MAX_PAYLOAD + 1), 11'd0);
        send_item(CMD_ALLOC, 16'd1, 11'd0);
        send_item(CMD_FREE, 16'd0, 11'd0);
        send_item(CMD_FREE, 16'd0, 11'd2);
        send_item(CMD_FREE, 16'd0, 11'(HEAP_BYTES));
        send_item(CMD_FREE, 16'hFFFF, 11'h7FF);
        send_item(CMD_FREE, 16'd0, 11'd12);
        send_item(CMD_FREE, 16'd0, 11'd4);
        send_item(CMD_FREE, 16'd0, 11'd4);
        send_item(CMD_ALLOC, 16'd1012, 11'd0);
        send_item(CMD_ALLOC, 16'd4, 11'd0);
        send_item(CMD_ALLOC, 16'd1, 11'd0);
        send_item(CMD_FREE, 16'd0, 11'd12);
        send_item(CMD_FREE, 16'd0, 11'd4);
        send_item(CMD_ALLOC, 16'(MAX_PAYLOAD), 11'd0);
        send_item(CMD_ALLOC, 16'd3, 11'd0);
        send_item(CMD_ALLOC, 16'd1009, 11'd0);
    endtask

    task automatic random_item();
        int               roll;
        int               pick;
        logic [REQ_W-1:0] want;
        roll = $urandom_range(99);
        if (roll < 6) begin
            send_item(1'($urandom_range(1)), REQ_W'($urandom()), OFF_W'($urandom()));
        end else if (roll < 12) begin
            send_item(CMD_FREE, REQ_W'($urandom()),
                      OFF_W'($urandom_range(1, SLOTS - 1) * HDR_BYTES));
        end else if (heap.held_offsets.size() > 0 &&
                     (roll < 52 || heap.held_offsets.size() > 24)) begin
            pick = $urandom_range(heap.held_offsets.size() - 1);
            send_item(CMD_FREE, REQ_W'($urandom()), OFF_W'(heap.held_offsets[pick]));
        end else begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                want = REQ_W'($urandom_range(1, 48));
            end else if (roll < 95) begin
                want = REQ_W'($urandom_range(1, 320));
            end else begin
                want = REQ_W'($urandom_range(1, MAX_PAYLOAD));
            end
            send_item(CMD_ALLOC, want, OFF_W'($urandom()));
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] margin;
        logic [CFG_W-1:0] interval;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            drain(8);
            case (p)
                0: begin
                    margin   = SPLIT_MARGIN_RST;
                    interval = MERGE_INTERVAL_RST;
                end
                1: begin
                    margin   = 8'd1;
                    interval = 8'd1;
                end
                2: begin
                    margin   = 8'd255;
                    interval = 8'd255;
                end
                3: begin
                    margin   = 8'd8;
                    interval = 8'd3;
                end
                default: begin
                    margin   = CFG_W'($urandom_range(1, 255));
                    interval = CFG_W'($urandom_range(1, 32));
                end
            endcase
            if (p > 0) begin
                write_register(REG_SPLIT_MARGIN, margin);
                write_register(REG_MERGE_INTERVAL, interval);
            end
            // one phase runs with no gaps on either side
            gap_pct = (p == 3) ? 0 : 20;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    drain(0);
                random_item();
            end
        end
        drain(300);
        if (heap.flaw == 0) begin
            $display("first_fit_heap_allocator_unit verification clean");
        end else begin
            $display("first_fit_heap_allocator_unit verification failed");
        end
        $finish;
    end

endmodule

/* first_fit_heap_allocator_unit.f */
hw/rtl/ffh_pkg.sv
hw/rtl/ffh_ram.sv
hw/rtl/ffh_walk_alu.sv
hw/rtl/first_fit_heap_allocator_unit.sv
tb/sv/first_fit_heap_allocator_unit_test.sv
